// ===== design/pi_tracking_loop_filter_macros.svh =====
// ----------------------------------------------------------------------------
// PI tracking loop filter assertion macros
// Concurrent check wrappers on clk with synchronous active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef PI_TRACKING_LOOP_FILTER_MACROS_SVH
`define PI_TRACKING_LOOP_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PITLF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PITLF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PITLF_ASSERT_IMP(label, ante, cons, msg)
`define PITLF_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== design/pitlf_pkg.sv =====
// ----------------------------------------------------------------------------
// pitlf_pkg
// Types, codes and saturation helpers for the PI tracking loop filter.
// ----------------------------------------------------------------------------
package pitlf_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INTEG_GAIN = 2'd1,
    CFG_TIME_STEP  = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] PROP_GAIN_RST  = 32'h0001_0000;
  localparam logic [31:0] INTEG_GAIN_RST = 32'h0000_0000;
  localparam logic [31:0] TIME_STEP_RST  = 32'd4294967;

  localparam logic [47:0] S48_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN = 48'h8000_0000_0000;

  // fraction bits dropped after each product
  localparam int SH_P    = 16;
  localparam int SH_I    = 48;
  localparam int SH_STEP = 32;

  // word offset of a partial product inside the accumulator
  typedef enum logic [1:0] {
    OFF_W0,
    OFF_W1,
    OFF_W2
  } mac_off_t;

  typedef struct packed {
    logic        issue;
    logic        first;
    mac_off_t    off;
    logic [31:0] a;
    logic [31:0] b;
  } mac_req_t;

  typedef struct packed {
    logic        sat;
    logic [47:0] val;
  } clip_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_SUM,
    S_P0,
    S_P1,
    S_I0,
    S_I1,
    S_I2,
    S_I3,
    S_VW,
    S_VS,
    S_VEL,
    S_ST0,
    S_ST1,
    S_SW,
    S_SR,
    S_POS
  } pitlf_state_t;

  // 49-bit two's complement sum down to 48 bits, clipped
  function automatic clip_t trim49(input logic [48:0] s);
    clip_t r;
    r.sat = s[48] ^ s[47];
    if (r.sat) begin
      r.val = s[48] ? S48_MIN : S48_MAX;
    end else begin
      r.val = s[47:0];
    end
    return r;
  endfunction

  // truncated product magnitude to signed 48 bits, clipped per sign
  function automatic clip_t mag_to_s48(input logic [127:0] mag, input logic neg);
    clip_t       r;
    logic [47:0] lim;
    logic [47:0] m;
    lim   = neg ? S48_MIN : S48_MAX;
    r.sat = (|mag[127:48]) || (mag[47:0] > lim);
    m     = r.sat ? lim : mag[47:0];
    r.val = neg ? (48'd0 - m) : m;
    return r;
  endfunction

endpackage

// ===== design/pitlf_in_if.sv =====
// ----------------------------------------------------------------------------
// pitlf_in_if
// Input channel: one encoder count per transaction.
// ----------------------------------------------------------------------------
interface pitlf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] count;

  modport source (output valid, output count, input ready);
  modport sink   (input valid, input count, output ready);
endinterface

// ===== design/pitlf_out_if.sv =====
// ----------------------------------------------------------------------------
// pitlf_out_if
// Result channel: position, velocity and clip flag per transaction.
// ----------------------------------------------------------------------------
interface pitlf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] position;
  logic signed [47:0] velocity;
  logic               saturated;

  modport source (output valid, output position, output velocity, output saturated,
                  input ready);
  modport sink   (input valid, input position, input velocity, input saturated,
                  output ready);
endinterface

// ===== design/pi_tracking_loop_filter.sv =====
// ----------------------------------------------------------------------------
// pi_tracking_loop_filter
// Type 2 PI tracking loop: encoder count in, filtered position and velocity out.
// ----------------------------------------------------------------------------
// The result is registered in S_POS, once the output register is free.
// Counts are taken when idle, one at a time; nine 32x32 partial products run
//   through the single shared multiplier, plus the error, clip and update steps.
// A finished result waits in the output register while the next count is taken.
// Reset (synchronous, rst_n low): gains and time step to their defaults,
//   previous count, error accumulator and position to zero, no result pending.
`include "pi_tracking_loop_filter_macros.svh"

module pi_tracking_loop_filter import pitlf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  pitlf_in_if.sink             in_ch,
  pitlf_out_if.source          out_ch
);

  // sequencer
  pitlf_state_t state_r, state_nxt;

  // configuration
  logic [31:0] kp_r, ki_r, dt_r;

  // loop state
  logic [31:0] prev_count_r, prev_count_nxt;
  logic [63:0] error_sum_r, error_sum_nxt;
  logic [47:0] pos_r, pos_nxt;

  // per-transaction working registers
  logic [31:0] c_r, c_nxt;
  logic [47:0] err_r, err_nxt;
  logic [47:0] errmag_r, errmag_nxt;
  logic        neg_err_r, neg_err_nxt;
  logic [63:0] summag_r, summag_nxt;
  logic        neg_sum_r, neg_sum_nxt;
  logic [63:0] kidt_r, kidt_nxt;
  logic [47:0] p_r, p_nxt;
  logic [47:0] i_r, i_nxt;
  logic [47:0] vel_r, vel_nxt;
  logic [47:0] velmag_r, velmag_nxt;
  logic        neg_vel_r, neg_vel_nxt;
  logic [47:0] step_r, step_nxt;
  logic        sat_r, sat_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_pos_r, out_pos_nxt;
  logic [47:0] out_vel_r, out_vel_nxt;
  logic        out_sat_r, out_sat_nxt;

  // shared multiplier
  mac_req_t     mac_req;
  logic [63:0]  mac_pp;
  logic [127:0] mac_acc;

  logic in_xact;
  logic out_free;

  // combinational helpers
  clip_t       err_c, vel_c, pos_c, p_c, i_c, step_c;
  logic [64:0] sum65;
  logic        sum_clear;

  assign in_xact  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  pitlf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .pp    (mac_pp),
    .acc   (mac_acc)
  );

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= PROP_GAIN_RST;
      ki_r <= INTEG_GAIN_RST;
      dt_r <= TIME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROP_GAIN:  kp_r <= cfg_wdata;
        CFG_INTEG_GAIN: ki_r <= cfg_wdata;
        CFG_TIME_STEP:  dt_r <= cfg_wdata;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_xact) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_P0;
      S_P0:    state_nxt = S_P1;
      S_P1:    state_nxt = S_I0;
      S_I0:    state_nxt = S_I1;
      S_I1:    state_nxt = S_I2;
      S_I2:    state_nxt = S_I3;
      S_I3:    state_nxt = S_VW;
      S_VW:    state_nxt = S_VS;
      S_VS:    state_nxt = S_VEL;
      S_VEL:   state_nxt = S_ST0;
      S_ST0:   state_nxt = S_ST1;
      S_ST1:   state_nxt = S_SW;
      S_SW:    state_nxt = S_SR;
      S_SR:    state_nxt = S_POS;
      S_POS:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ------------------------------------------------------ sequencer outputs
  // Partial product schedule. The accumulator holds an operation's full
  // product once its last issue has passed the pp and accumulator registers,
  // while a directly following operation's first product is only in the pp register.
  always_comb begin
    in_ch.ready   = (state_r == S_IDLE);
    mac_req.issue = 1'b1;
    mac_req.first = 1'b0;
    mac_req.off   = OFF_W0;
    mac_req.a     = '0;
    mac_req.b     = '0;
    case (state_r)
      S_ERR: begin  // ki*dt, single product, taken from pp
        mac_req.first = 1'b1;
        mac_req.a     = ki_r;
        mac_req.b     = dt_r;
      end
      S_P0: begin
        mac_req.first = 1'b1;
        mac_req.a     = errmag_r[31:0];
        mac_req.b     = kp_r;
      end
      S_P1: begin
        mac_req.off = OFF_W1;
        mac_req.a   = {16'd0, errmag_r[47:32]};
        mac_req.b   = kp_r;
      end
      S_I0: begin
        mac_req.first = 1'b1;
        mac_req.a     = summag_r[31:0];
        mac_req.b     = kidt_r[31:0];
      end
      S_I1: begin
        mac_req.off = OFF_W1;
        mac_req.a   = summag_r[31:0];
        mac_req.b   = kidt_r[63:32];
      end
      S_I2: begin
        mac_req.off = OFF_W1;
        mac_req.a   = summag_r[63:32];
        mac_req.b   = kidt_r[31:0];
      end
      S_I3: begin
        mac_req.off = OFF_W2;
        mac_req.a   = summag_r[63:32];
        mac_req.b   = kidt_r[63:32];
      end
      S_ST0: begin
        mac_req.first = 1'b1;
        mac_req.a     = velmag_r[31:0];
        mac_req.b     = dt_r;
      end
      S_ST1: begin
        mac_req.off = OFF_W1;
        mac_req.a   = {16'd0, velmag_r[47:32]};
        mac_req.b   = dt_r;
      end
      default: mac_req.issue = 1'b0;
    endcase
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    c_nxt          = c_r;
    err_nxt        = err_r;
    errmag_nxt     = errmag_r;
    neg_err_nxt    = neg_err_r;
    summag_nxt     = summag_r;
    neg_sum_nxt    = neg_sum_r;
    kidt_nxt       = kidt_r;
    p_nxt          = p_r;
    i_nxt          = i_r;
    vel_nxt        = vel_r;
    velmag_nxt     = velmag_r;
    neg_vel_nxt    = neg_vel_r;
    step_nxt       = step_r;
    sat_nxt        = sat_r;
    prev_count_nxt = prev_count_r;
    error_sum_nxt  = error_sum_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_pos_nxt    = out_pos_r;
    out_vel_nxt    = out_vel_r;
    out_sat_nxt    = out_sat_r;

    // error = count*2^16 - position
    err_c  = trim49({c_r[31], c_r, 16'd0} - {pos_r[47], pos_r});
    sum65  = {error_sum_r[63], error_sum_r} + {{17{err_r[47]}}, err_r};
    // count unchanged and locked on: accumulator drops out
    sum_clear = (c_r == prev_count_r) && (err_r == '0);
    p_c    = mag_to_s48(mac_acc >> SH_P, neg_err_r);
    i_c    = mag_to_s48(mac_acc >> SH_I, neg_sum_r);
    vel_c  = trim49({p_r[47], p_r} + {i_r[47], i_r});
    step_c = mag_to_s48(mac_acc >> SH_STEP, neg_vel_r);
    pos_c  = trim49({pos_r[47], pos_r} + {step_r[47], step_r});

    case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          c_nxt   = in_ch.count;
          sat_nxt = 1'b0;
        end
      end
      S_ERR: begin
        err_nxt = err_c.val;
        sat_nxt = sat_r | err_c.sat;
      end
      S_SUM: begin
        kidt_nxt       = mac_pp;
        prev_count_nxt = c_r;
        neg_err_nxt    = err_r[47];
        errmag_nxt     = err_r[47] ? (48'd0 - err_r) : err_r;
        if (sum_clear) begin
          error_sum_nxt = '0;
        end else if (sum65[64] ^ sum65[63]) begin
          error_sum_nxt = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          sat_nxt       = 1'b1;
        end else begin
          error_sum_nxt = sum65[63:0];
        end
      end
      S_P0: begin
        neg_sum_nxt = error_sum_r[63];
        summag_nxt  = error_sum_r[63] ? (64'd0 - error_sum_r) : error_sum_r;
      end
      S_I1: begin
        p_nxt   = p_c.val;
        sat_nxt = sat_r | p_c.sat;
      end
      S_VS: begin
        i_nxt   = i_c.val;
        sat_nxt = sat_r | i_c.sat;
      end
      S_VEL: begin
        vel_nxt     = vel_c.val;
        neg_vel_nxt = vel_c.val[47];
        velmag_nxt  = vel_c.val[47] ? (48'd0 - vel_c.val) : vel_c.val;
        sat_nxt     = sat_r | vel_c.sat;
      end
      S_SR: begin
        step_nxt = step_c.val;
        sat_nxt  = sat_r | step_c.sat;
      end
      S_POS: begin
        if (out_free) begin
          pos_nxt       = pos_c.val;
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_c.val;
          out_vel_nxt   = vel_r;
          out_sat_nxt   = sat_r | pos_c.sat;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      prev_count_r <= '0;
      error_sum_r  <= '0;
      pos_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      prev_count_r <= prev_count_nxt;
      error_sum_r  <= error_sum_nxt;
      pos_r        <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    err_r     <= err_nxt;
    errmag_r  <= errmag_nxt;
    neg_err_r <= neg_err_nxt;
    summag_r  <= summag_nxt;
    neg_sum_r <= neg_sum_nxt;
    kidt_r    <= kidt_nxt;
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    vel_r     <= vel_nxt;
    velmag_r  <= velmag_nxt;
    neg_vel_r <= neg_vel_nxt;
    step_r    <= step_nxt;
    sat_r     <= sat_nxt;
    out_pos_r <= out_pos_nxt;
    out_vel_r <= out_vel_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.velocity  = out_vel_r;
  assign out_ch.saturated = out_sat_r;

  // ------------------------------------------------------------ assertions
  `PITLF_ASSERT_NXT(a_xact_starts_seq, in_xact, state_r == S_ERR,
                    "input transaction did not start the sequence")
  `PITLF_ASSERT_NXT(a_sat_cleared, in_xact, !sat_r,
                    "clip flag not cleared for new transaction")
  `PITLF_ASSERT_NXT(a_result_posted, (state_r == S_POS) && out_free,
                    out_valid_r && (state_r == S_IDLE),
                    "result not posted on sequence end")
  `PITLF_ASSERT_IMP(a_no_mac_when_idle, state_r == S_IDLE, !mac_req.issue,
                    "multiplier issued while idle")

endmodule

// ===== design/pitlf_mac.sv =====
// ----------------------------------------------------------------------------
// pitlf_mac
// Shared 32x32 multiplier with registered product and 128-bit accumulator.
// ----------------------------------------------------------------------------
module pitlf_mac import pitlf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  mac_req_t     req,
  output logic [63:0]  pp,
  output logic [127:0] acc
);

  logic         pp_vld_r;
  logic         pp_first_r;
  mac_off_t     pp_off_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [127:0] addend;
  logic [127:0] acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= req.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      pp_r       <= {32'd0, req.a} * {32'd0, req.b};
      pp_first_r <= req.first;
      pp_off_r   <= req.off;
    end
    if (pp_vld_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    case (pp_off_r)
      OFF_W0:  addend = {64'd0, pp_r};
      OFF_W1:  addend = {32'd0, pp_r, 32'd0};
      OFF_W2:  addend = {pp_r, 64'd0};
      default: addend = '0;
    endcase
    acc_nxt = (pp_first_r ? 128'd0 : acc_r) + addend;
  end

  assign pp  = pp_r;
  assign acc = acc_r;

endmodule
